// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue top level and its cells.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W      = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - WORD_W - STATUS_W - FILL_W;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    localparam logic [WORD_W-1:0] WORD_ALL_ONES = {WORD_W{1'b1}};

    // broadcast from the control to every cell
    typedef struct packed {
        logic              en;
        logic [KIND_W-1:0] kind;
        logic              tap_shift;
        logic [WORD_W-1:0] value;
    } deq_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic              occ;
        logic [WORD_W-1:0] data;
    } deq_link_t;

endpackage

// ----- rtl/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain: a word, an occupied flag and a tap stage that
// carries a word popped from the back toward cell zero.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  deq_pkg::deq_cmd_t                 cmd,
    input  deq_pkg::deq_link_t                left_in,
    input  deq_pkg::deq_link_t                right_in,
    input  logic [deq_pkg::WORD_W-1:0]        tap_in,
    output deq_pkg::deq_link_t                link_out,
    output logic [deq_pkg::WORD_W-1:0]        tap_out
);

    logic                       occ_reg;
    logic                       occ_next;
    logic [deq_pkg::WORD_W-1:0] data_reg;
    logic [deq_pkg::WORD_W-1:0] data_next;
    logic [deq_pkg::WORD_W-1:0] tap_reg;
    logic [deq_pkg::WORD_W-1:0] tap_next;

    always_comb begin
        occ_next  = occ_reg;
        data_next = data_reg;
        tap_next  = cmd.tap_shift ? tap_in : tap_reg;
        if (cmd.en) begin
            case (cmd.kind)
                deq_pkg::KIND_PUSH_FRONT: begin
                    occ_next  = left_in.occ;
                    data_next = left_in.data;
                end
                deq_pkg::KIND_PUSH_BACK: begin
                    // first free slot takes the word
                    if (!occ_reg && left_in.occ) begin
                        occ_next  = 1'b1;
                        data_next = cmd.value;
                    end
                end
                deq_pkg::KIND_POP_FRONT: begin
                    occ_next  = right_in.occ;
                    data_next = right_in.data;
                end
                deq_pkg::KIND_POP_BACK: begin
                    // tail slot frees itself and hands its word to the tap
                    if (occ_reg && !right_in.occ) begin
                        occ_next = 1'b0;
                        tap_next = data_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign link_out.occ  = occ_reg;
    assign link_out.data = data_reg;
    assign tap_out       = tap_reg;

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed 32-bit words in a shifting chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one operation per transaction, the kind in
// s_tuser (0 push front, 1 push back, 2 pop front, 3 pop back) and the word to
// push in s_tdata. Every operation returns one transaction on the output
// stream with the popped word, a status (done, underflow, overflow) and the
// fill level after the operation.
// The front word always sits in cell zero; pushes and pops at the front shift
// the whole chain by one cell, a push at the back fills the first free cell.
// For push front, push back, pop front and any refused operation the result is
// in the output register the cycle after acceptance.
// A pop from the back travels from the tail cell to cell zero through the tap
// chain, one cell per cycle; once it reaches cell zero its result is loaded
// into the output register as soon as that register is free.
// One operation is in flight at a time; s_tready is low while a back pop is
// travelling or while the output register is full and m_tready is low.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: push_value[31:0]
    input  logic [deq_pkg::WORD_W-1:0]            s_tdata,
    // s_tuser: kind[1:0]
    input  logic [deq_pkg::KIND_W-1:0]            s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // m_tdata: popped_value[31:0], status[33:32], fill_level[38:34], zero[39]
    output logic [deq_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [CW-1:0]                      cnt_reg;
    logic [CW-1:0]                      cnt_next;
    logic [AW-1:0]                      wait_reg;
    logic [AW-1:0]                      wait_next;
    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;
    logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata_next;

    logic                               s_accept;
    logic                               out_free;
    logic                               is_push;
    logic                               full;
    logic                               empty;
    logic                               load_out;
    logic [deq_pkg::WORD_W-1:0]         popped;
    logic [deq_pkg::STATUS_W-1:0]       status;
    logic [CW+deq_pkg::FILL_W-1:0]      cnt_ext;
    logic [CW-1:0]                      cnt_less_one;

    deq_pkg::deq_cmd_t                  cmd;
    deq_pkg::deq_link_t                 link [DEPTH];
    logic [deq_pkg::WORD_W-1:0]         tap  [DEPTH];

    // chain of cells, cell zero holds the front word
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        deq_pkg::deq_link_t         left_in;
        deq_pkg::deq_link_t         right_in;
        logic [deq_pkg::WORD_W-1:0] tap_in;

        if (i == 0) begin : g_first
            assign left_in.occ  = 1'b1;
            assign left_in.data = cmd.value;
        end else begin : g_mid_left
            assign left_in = link[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_in.occ  = 1'b0;
            assign right_in.data = '0;
            assign tap_in        = '0;
        end else begin : g_mid_right
            assign right_in = link[i+1];
            assign tap_in   = tap[i+1];
        end

        deq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .left_in  (left_in),
            .right_in (right_in),
            .tap_in   (tap_in),
            .link_out (link[i]),
            .tap_out  (tap[i])
        );
    end

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = (state_reg == S_IDLE) && out_free;
    assign s_accept     = s_tvalid && s_tready;
    assign is_push      = (s_tuser == deq_pkg::KIND_PUSH_FRONT) ||
                          (s_tuser == deq_pkg::KIND_PUSH_BACK);
    assign full         = (cnt_reg == CW'(DEPTH));
    assign empty        = (cnt_reg == '0);
    assign cnt_less_one = cnt_reg - CW'(1);

    assign cmd.en        = s_accept && (is_push ? !full : !empty);
    assign cmd.kind      = s_tuser;
    assign cmd.value     = s_tdata;
    assign cmd.tap_shift = (state_reg == S_WAIT) && (wait_reg != '0);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load_out      = 1'b0;
        popped        = '0;
        status        = deq_pkg::ST_DONE;

        if (s_accept) begin
            if (is_push) begin
                load_out = 1'b1;
                if (full) begin
                    status = deq_pkg::ST_OVERFLOW;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end else if (empty) begin
                load_out = 1'b1;
                popped   = deq_pkg::WORD_ALL_ONES;
                status   = deq_pkg::ST_UNDERFLOW;
            end else if (s_tuser == deq_pkg::KIND_POP_FRONT) begin
                load_out = 1'b1;
                popped   = link[0].data;
                cnt_next = cnt_less_one;
            end else begin
                // tail sits at cell count-1, that many tap shifts to cell zero
                cnt_next   = cnt_less_one;
                wait_next  = cnt_less_one[AW-1:0];
                state_next = S_WAIT;
            end
        end

        if (state_reg == S_WAIT) begin
            if (wait_reg != '0) begin
                wait_next = wait_reg - AW'(1);
            end else if (out_free) begin
                load_out   = 1'b1;
                popped     = tap[0];
                state_next = S_IDLE;
            end
        end

        cnt_ext      = {{deq_pkg::FILL_W{1'b0}}, cnt_next};
        m_tdata_next = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{deq_pkg::OUT_PAD_W{1'b0}},
                             cnt_ext[deq_pkg::FILL_W-1:0], status, popped};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            wait_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/tb_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the double-ended queue: a circular-buffer predictor
// runs beside the block and each output transaction is compared with it.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // same bit order as m_tdata: word lowest, then status, then fill
    typedef struct packed {
        logic [deq_pkg::FILL_W-1:0]   fill;
        logic [deq_pkg::STATUS_W-1:0] status;
        logic [deq_pkg::WORD_W-1:0]   word;
    } deq_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic [deq_pkg::WORD_W-1:0]      s_tdata  = '0;
    logic [deq_pkg::KIND_W-1:0]      s_tuser  = deq_pkg::KIND_PUSH_FRONT;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;

    // predictor state: circular store with front slot, one-past-back slot, count
    logic [deq_pkg::WORD_W-1:0]      ring_words [DEPTH];
    int unsigned                     ring_front;
    int unsigned                     ring_back;
    int unsigned                     ring_count;

    deq_result_t                     expected_results [$];
    int                              mismatch_count;
    int                              cycle_count;
    int                              out_stall;
    bit                              idle_in;
    bit                              idle_out;
    int                              n_pushes;
    int                              n_pops;
    int                              n_underflows;
    int                              n_overflows;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // apply one operation to the predictor and return its result
    function automatic deq_result_t deque_apply(input logic [deq_pkg::KIND_W-1:0] kind,
                                                input logic [deq_pkg::WORD_W-1:0] value);
        deq_result_t res;
        res.word   = '0;
        res.status = deq_pkg::ST_DONE;
        if (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_BACK) begin
            n_pushes++;
            if (ring_count >= DEPTH) begin
                res.status = deq_pkg::ST_OVERFLOW;
                n_overflows++;
            end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
                ring_front = (ring_front == 0) ? DEPTH - 1 : ring_front - 1;
                ring_words[ring_front] = value;
                ring_count++;
            end else begin
                ring_words[ring_back] = value;
                ring_back = (ring_back + 1) % DEPTH;
                ring_count++;
            end
        end else begin
            n_pops++;
            if (ring_count == 0) begin
                res.word   = deq_pkg::WORD_ALL_ONES;
                res.status = deq_pkg::ST_UNDERFLOW;
                n_underflows++;
            end else if (kind == deq_pkg::KIND_POP_FRONT) begin
                res.word   = ring_words[ring_front];
                ring_front = (ring_front + 1) % DEPTH;
                ring_count--;
            end else begin
                ring_back = (ring_back == 0) ? DEPTH - 1 : ring_back - 1;
                res.word  = ring_words[ring_back];
                ring_count--;
            end
        end
        res.fill = ring_count[deq_pkg::FILL_W-1:0];
        return res;
    endfunction

    // drive one operation and record its expected result on acceptance
    task automatic send_op(input logic [deq_pkg::KIND_W-1:0] kind,
                           input logic [deq_pkg::WORD_W-1:0] value);
        int gap;
        gap = idle_in ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(deque_apply(kind, value));
    endtask

    // output side: compare each transaction, then draw the next stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result transaction: m_tdata %h", m_tdata);
                end else begin
                    deq_result_t want;
                    bit          bad;
                    want = expected_results.pop_front();
                    bad  = (m_tdata[deq_pkg::OUT_TDATA_W-2:0] !== want) ||
                           (m_tdata[deq_pkg::OUT_TDATA_W-1] !== 1'b0);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: word %h/%h status %0d/%0d fill %0d/%0d pad %b",
                                     want.word, m_tdata[31:0], want.status, m_tdata[33:32],
                                     want.fill, m_tdata[38:34], m_tdata[39]);
                    end
                end
                out_stall = idle_out ? $urandom_range(0, 4) : 0;
            end
            if (out_stall > 0) begin
                m_tready <= 1'b0;
                out_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // extreme words at both ends, pops on empty, emptying from one end and
    // refilling from the other
    task automatic test_extremes();
        send_op(deq_pkg::KIND_POP_FRONT, 32'h1234_5678);
        send_op(deq_pkg::KIND_POP_BACK, 32'hFFFF_FFFF);
        send_op(deq_pkg::KIND_PUSH_BACK, 32'h8000_0000);
        send_op(deq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(deq_pkg::KIND_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(deq_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
        // all-ones word popped with status done, not underflow
        send_op(deq_pkg::KIND_POP_BACK, 32'h0);
        send_op(deq_pkg::KIND_POP_FRONT, 32'h0);
        send_op(deq_pkg::KIND_POP_FRONT, 32'h0);
        send_op(deq_pkg::KIND_POP_BACK, 32'h0);
        send_op(deq_pkg::KIND_POP_BACK, 32'h0);
        send_op(deq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
        send_op(deq_pkg::KIND_POP_BACK, 32'h0);
        send_op(deq_pkg::KIND_PUSH_BACK, 32'hAAAA_AAAA);
        send_op(deq_pkg::KIND_POP_FRONT, 32'h0);
    endtask

    // fill from both ends, then push at each end while full
    task automatic test_overflow();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_op((i % 2) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK,
                    32'h0100_0000 * i + i);
        send_op(deq_pkg::KIND_PUSH_FRONT, 32'hDEAD_0001);
        send_op(deq_pkg::KIND_PUSH_BACK, 32'hDEAD_0002);
    endtask

    // random walk that alternates between growing and shrinking so the fill
    // level sweeps the whole range and the pointers wrap many times
    task automatic test_random_ops(input int n_ops);
        int i;
        int r;
        bit growing;
        bit is_push;
        logic [deq_pkg::KIND_W-1:0] kind;
        logic [deq_pkg::WORD_W-1:0] value;
        growing = 1'b0;
        for (i = 0; i < n_ops; i++) begin
            if (i % 40 == 0) begin
                idle_in  = ($urandom_range(0, 3) != 0);
                idle_out = ($urandom_range(0, 3) != 0);
            end
            if (ring_count == DEPTH && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (ring_count == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 24) == 0)
                growing = !growing;
            r = $urandom_range(0, 99);
            is_push = growing ? (r < 75) : (r < 25);
            if (is_push)
                kind = $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT
                                            : deq_pkg::KIND_PUSH_BACK;
            else
                kind = $urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT
                                            : deq_pkg::KIND_POP_BACK;
            case ($urandom_range(0, 11))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'hFFFF_FFFF;
                3:       value = 32'h0000_0000;
                default: value = $urandom;
            endcase
            send_op(kind, value);
        end
    endtask

    initial begin
        ring_front     = 0;
        ring_back      = 0;
        ring_count     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_in        = 1'b1;
        idle_out       = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_overflow();
        test_random_ops(520);
        s_tvalid <= 1'b0;

        // wait for every outstanding result, including a back pop still in the tap chain
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);

        $display("ran %0d operations: %0d pushes (%0d dropped full), %0d pops (%0d on empty)",
                 n_pushes + n_pops, n_pushes, n_overflows, n_pops, n_underflows);
        $display("output mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
